[design/afmf_pkg.sv]
// Shared constants and types for the addressed frame message filter.
`timescale 1ns / 1ps

package afmf_pkg;

  localparam int MSG_CAP     = 64;
  localparam int ID_BITS     = 16;
  localparam int STORE_DEPTH = MSG_CAP - 1;
  localparam int LEN_W       = $clog2(MSG_CAP);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SUM_W       = ID_BITS + 4;
  localparam int CMP_W       = (ID_BITS > 16) ? ID_BITS : 16;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID = 8'd1;

  localparam logic [7:0] CH_START = 8'h3C;  // '<'
  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_END   = 8'h3E;  // '>'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_STORE,
    CMD_RELEASE
  } cmd_op_t;

  // len carries the store address for CMD_STORE, the message length for CMD_RELEASE
  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

[design/afmf_if.sv]
// Channel interfaces: received bytes, released bytes and configuration writes.
`timescale 1ns / 1ps

interface afmf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afmf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface afmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [afmf_pkg::CFG_IDX_W-1:0]  index;
  logic [afmf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/afmf_cmd_fifo.sv]
// Small command queue between the frame parser and the output sequencer.
`timescale 1ns / 1ps

module afmf_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  afmf_pkg::cmd_t   push_cmd,
  output logic             full,
  input  logic             pop,
  output afmf_pkg::cmd_t   head,
  output logic             empty
);

  afmf_pkg::cmd_t entries [afmf_pkg::FIFO_DEPTH];
  logic [afmf_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [afmf_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [afmf_pkg::FIFO_PTR_W:0]   count;

  assign full  = (count == (afmf_pkg::FIFO_PTR_W+1)'(afmf_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/afmf_front.sv]
// Front end: config registers, frame parser, id match; emits one command per byte at most.
`timescale 1ns / 1ps

module afmf_front (
  input  logic            clk,
  input  logic            rst,
  afmf_rx_if.sink         rx,
  afmf_cfg_if.sink        cfg,
  output logic            push,
  output afmf_pkg::cmd_t  push_cmd,
  input  logic            fifo_full
);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ID,
    PH_TEXT,
    PH_RELEASE
  } phase_t;

  phase_t                          phase, phase_next;
  logic [afmf_pkg::ID_BITS-1:0]    acc, acc_next;
  logic                            ovf, ovf_next;
  logic [afmf_pkg::LEN_W-1:0]      len, len_next;
  logic                            filter_on;
  logic [15:0]                     target_id;
  logic                            accept;
  logic [afmf_pkg::SUM_W-1:0]      id_sum;
  logic                            id_match;

  assign rx.ready  = !fifo_full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;

  // acc*10 + digit as two shifted adds
  assign id_sum = afmf_pkg::SUM_W'({acc, 3'b000}) + afmf_pkg::SUM_W'({acc, 1'b0})
                + afmf_pkg::SUM_W'(rx.rx_byte - afmf_pkg::CH_ZERO);
  assign id_match = !ovf &&
                    (afmf_pkg::CMP_W'(acc) == afmf_pkg::CMP_W'(target_id));

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    len_next   = len;
    push       = 1'b0;
    push_cmd   = '{op: afmf_pkg::CMD_PASS, data: rx.rx_byte, len: len};
    if (accept) begin
      if (!filter_on) begin
        push = 1'b1;
      end else begin
        case (phase)
          PH_WAIT: begin
            acc_next = '0;
            ovf_next = 1'b0;
            len_next = '0;
            if (rx.rx_byte == afmf_pkg::CH_START) begin
              phase_next = PH_ID;
            end
          end
          PH_ID: begin
            if (rx.rx_byte inside {[afmf_pkg::CH_ZERO:afmf_pkg::CH_NINE]}) begin
              acc_next = id_sum[afmf_pkg::ID_BITS-1:0];
              if (id_sum[afmf_pkg::SUM_W-1:afmf_pkg::ID_BITS] != '0) begin
                ovf_next = 1'b1;
              end
            end else if (rx.rx_byte == afmf_pkg::CH_AT) begin
              phase_next = PH_TEXT;
            end else begin
              phase_next = PH_WAIT;
            end
          end
          PH_TEXT: begin
            if (!id_match) begin
              phase_next = PH_WAIT;
            end else if (rx.rx_byte == afmf_pkg::CH_END) begin
              phase_next = PH_RELEASE;
            end else begin
              push          = 1'b1;
              push_cmd.op   = afmf_pkg::CMD_STORE;
              len_next      = len + 1'b1;
              if (len_next == afmf_pkg::LEN_W'(afmf_pkg::STORE_DEPTH)) begin
                phase_next = PH_RELEASE;
              end
            end
          end
          default: begin
            // trigger byte is dropped, stored text goes out
            push        = 1'b1;
            push_cmd.op = afmf_pkg::CMD_RELEASE;
            phase_next  = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      acc       <= '0;
      ovf       <= 1'b0;
      len       <= '0;
      filter_on <= 1'b0;
      target_id <= '0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      ovf   <= ovf_next;
      len   <= len_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          afmf_pkg::CFG_FILTER_ON: filter_on <= cfg.data[0];
          afmf_pkg::CFG_TARGET_ID: target_id <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule

[design/afmf_back.sv]
// Back end: message store and output sequencer driving the registered output stage.
`timescale 1ns / 1ps

module afmf_back (
  input  logic            clk,
  input  logic            rst,
  input  afmf_pkg::cmd_t  head,
  input  logic            fifo_empty,
  output logic            pop,
  afmf_tx_if.source       tx
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND,
    B_NL
  } back_state_t;

  back_state_t                  state;
  logic [7:0]                   store [afmf_pkg::STORE_DEPTH];
  logic [7:0]                   rd_data;
  logic [afmf_pkg::LEN_W-1:0]   idx;
  logic [afmf_pkg::LEN_W-1:0]   idx_next;
  logic [afmf_pkg::LEN_W-1:0]   rel_len;
  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         out_last;
  logic                         out_free;
  logic                         out_load;
  logic                         wr_en;

  assign tx.valid    = out_valid;
  assign tx.out_byte = out_byte;
  assign tx.last     = out_last;

  assign out_free = !out_valid || tx.ready;
  assign idx_next = idx + 1'b1;
  assign pop = (state == B_IDLE) && !fifo_empty &&
               ((head.op != afmf_pkg::CMD_PASS) || out_free);
  assign wr_en = pop && (head.op == afmf_pkg::CMD_STORE);

  // output register takes a new byte this cycle
  assign out_load = (state == B_IDLE) ? (pop && (head.op == afmf_pkg::CMD_PASS))
                  : (((state == B_SEND) || (state == B_NL)) && out_free);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[head.len[afmf_pkg::ADDR_W-1:0]] <= head.data;
    end
    if (state == B_READ) begin
      rd_data <= store[idx[afmf_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (tx.valid && tx.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            case (head.op)
              afmf_pkg::CMD_PASS: begin
                out_byte  <= head.data;
                out_last  <= 1'b1;
              end
              afmf_pkg::CMD_RELEASE: begin
                rel_len <= head.len;
                idx     <= '0;
                state   <= (head.len == '0) ? B_NL : B_READ;
              end
              default: ;
            endcase
          end
        end
        B_READ: begin
          state <= B_SEND;
        end
        B_SEND: begin
          if (out_free) begin
            out_byte  <= rd_data;
            out_last  <= 1'b0;
            idx       <= idx_next;
            state     <= (idx_next == rel_len) ? B_NL : B_READ;
          end
        end
        default: begin
          if (out_free) begin
            out_byte  <= afmf_pkg::CH_NL;
            out_last  <= 1'b1;
            state     <= B_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[design/addressed_frame_message_filter.sv]
// Top level of the addressed frame message filter.
`timescale 1ns / 1ps

// Usage:
//  - rx: received bytes, one per transaction (valid/ready).
//  - tx: released bytes with a last flag, one per transaction (valid/ready).
//  - cfg: register writes; index 0 = filter_on, index 1 = target_id. Always ready.
//    Write only while the block is idle.
//  - filter_on = 0: every byte comes out as a run of one with last set,
//    passing through the command queue and the registered output stage,
//    one byte per cycle sustained while tx is ready.
//  - filter_on = 1: frames '<' id '@' text '>' are parsed; text of a frame whose
//    id equals target_id is stored and released on the following byte,
//    then a newline with last set. A release reads each stored byte from the
//    store and loads it into the output register, one after the other, and
//    then loads the newline; a store command only writes the store.
//  - A 4-entry command queue separates parser and sequencer, so rx keeps
//    flowing while a release drains; rx stalls only when the queue is full.
//  - tx stall: output register holds its transaction; sequencer waits.
//  - Reset (rst, synchronous): parser back to waiting for '<', registers
//    cleared, queue and output emptied. Message store is not cleared.

module addressed_frame_message_filter (
  input  logic       clk,
  input  logic       rst,
  afmf_rx_if.sink    rx,
  afmf_tx_if.source  tx,
  afmf_cfg_if.sink   cfg
);

  logic            push;
  afmf_pkg::cmd_t  push_cmd;
  logic            fifo_full;
  logic            pop;
  afmf_pkg::cmd_t  head;
  logic            fifo_empty;

  // parser and config registers
  afmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  // command queue: pass / store / release
  afmf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty)
  );

  // store writes and output sequencing
  afmf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .tx         (tx)
  );

endmodule
